// ----- hw/rtl/stk_pkg.sv -----
`default_nettype none
package stk_pkg;

  localparam int MAX_NEST = 255;
  localparam int NEST_W = $clog2(MAX_NEST + 1);
  localparam int MAX_RES = 4;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_QUOTE   = 3'd3,
    MODE_PAREN   = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic       tok_end;
  } res_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0] cnt;
    res_t [MAX_RES-1:0]   res;
  } cmd_t;

  typedef struct packed {
    mode_t             mode;
    logic [NEST_W-1:0] nest_depth;
    logic              token_open;
    logic              slash_pending;
    logic              drop_next;
  } lex_t;

  typedef struct packed {
    lex_t st;
    cmd_t cmd;
  } work_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam lex_t LEX_RESET = '{
    mode: MODE_IDLE,
    nest_depth: '0,
    token_open: 1'b0,
    slash_pending: 1'b0,
    drop_next: 1'b0
  };

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) ||
           (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic work_t put_byte(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    if (r.cmd.cnt < RES_CNT_W'(MAX_RES)) begin
      r.cmd.res[r.cmd.cnt[RES_IDX_W-1:0]] = '{tok_byte: b, tok_end: 1'b0};
      r.cmd.cnt = r.cmd.cnt + RES_CNT_W'(1);
    end
    r.st.token_open = 1'b1;
    return r;
  endfunction

  function automatic work_t end_token(work_t w);
    work_t r;
    r = w;
    if (r.st.token_open && (r.cmd.cnt < RES_CNT_W'(MAX_RES))) begin
      r.cmd.res[r.cmd.cnt[RES_IDX_W-1:0]] = '{tok_byte: 8'h00, tok_end: 1'b1};
      r.cmd.cnt = r.cmd.cnt + RES_CNT_W'(1);
    end
    r.st.token_open = 1'b0;
    return r;
  endfunction

  function automatic work_t plain_byte(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (is_ws(c)) begin
      r = end_token(r);
      r.st.mode = MODE_IDLE;
    end else if (c == CH_BSLASH) begin
      r.st.drop_next = 1'b1;
    end else if (c == CH_QUOTE) begin
      r = put_byte(r, c);
      r.st.mode = MODE_QUOTE;
    end else if (c == CH_LPAREN) begin
      r = put_byte(r, c);
      r.st.nest_depth = NEST_W'(1);
      r.st.mode = MODE_PAREN;
    end else if ((c == CH_RPAREN) || (c == CH_LBRACK) || (c == CH_RBRACK)) begin
      r = end_token(r);
      r = put_byte(r, c);
      r = end_token(r);
      r.st.mode = MODE_IDLE;
    end else if (c == CH_SLASH) begin
      r.st.slash_pending = 1'b1;
    end else begin
      r = put_byte(r, c);
      r.st.mode = MODE_WORD;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/stk_chan_if.sv -----
`default_nettype none
interface stk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       final_req;

  modport source (output valid, output ch, output final_req, input ready);
  modport sink (input valid, input ch, input final_req, output ready);
endinterface

interface stk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tok_byte;
  logic       tok_end;
  logic       run_last;

  modport source (output valid, output tok_byte, output tok_end, output run_last,
                  input ready);
  modport sink (input valid, input tok_byte, input tok_end, input run_last,
                output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/stk_front.sv -----
`default_nettype none
module stk_front
  import stk_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  stk_in_if.sink    in_chan,
  input  wire logic q_full,
  output push_t     push
);

  lex_t  lex_r;
  lex_t  lex_nxt;
  work_t w;
  logic  accept;

  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && !q_full;

  always_comb begin
    w.st = lex_r;
    w.cmd = '0;
    if (lex_r.drop_next) begin
      w.st.drop_next = 1'b0;
    end else if (lex_r.slash_pending) begin
      w.st.slash_pending = 1'b0;
      if (in_chan.ch == CH_SLASH) begin
        w = end_token(w);
        w.st.mode = MODE_COMMENT;
      end else begin
        w = put_byte(w, CH_SLASH);
        w.st.mode = MODE_WORD;
        w = plain_byte(w, in_chan.ch);
      end
    end else begin
      case (lex_r.mode)
        MODE_COMMENT: begin
          if (in_chan.ch == CH_NL) begin
            w.st.mode = MODE_IDLE;
          end
        end
        MODE_QUOTE: begin
          if (in_chan.ch == CH_BSLASH) begin
            w.st.drop_next = 1'b1;
          end else if (in_chan.ch == CH_QUOTE) begin
            w = put_byte(w, in_chan.ch);
            w = end_token(w);
            w.st.mode = MODE_IDLE;
          end else begin
            w = put_byte(w, in_chan.ch);
          end
        end
        MODE_PAREN: begin
          w = put_byte(w, in_chan.ch);
          if (in_chan.ch == CH_LPAREN) begin
            if (lex_r.nest_depth < NEST_W'(MAX_NEST)) begin
              w.st.nest_depth = lex_r.nest_depth + NEST_W'(1);
            end
          end else if (in_chan.ch == CH_RPAREN) begin
            if (lex_r.nest_depth != '0) begin
              w.st.nest_depth = lex_r.nest_depth - NEST_W'(1);
            end
            if (w.st.nest_depth == '0) begin
              w = end_token(w);
              w.st.mode = MODE_IDLE;
            end
          end
        end
        default: begin
          w = plain_byte(w, in_chan.ch);
        end
      endcase
    end
    if (in_chan.final_req) begin
      if (w.st.slash_pending) begin
        w.st.slash_pending = 1'b0;
        w = put_byte(w, CH_SLASH);
      end
      w = end_token(w);
      w.st = LEX_RESET;
    end
  end

  assign lex_nxt = accept ? w.st : lex_r;
  assign push.valid = accept && (w.cmd.cnt != '0);
  assign push.cmd = w.cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_r <= LEX_RESET;
    end else begin
      lex_r <= lex_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/stk_queue.sv -----
`default_nettype none
module stk_queue
  import stk_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  input  wire logic  pop,
  output cmd_t       head,
  output q_stat_t    stat
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.full = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push = push.valid && !stat.full;
  assign do_pop = pop && !stat.empty;
  assign head = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/stk_back.sv -----
`default_nettype none
module stk_back
  import stk_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cmd_t    head,
  input  wire q_stat_t stat,
  output logic         pop,
  stk_out_if.source    out_chan
);

  logic [RES_IDX_W-1:0] idx_r;
  logic [RES_IDX_W-1:0] idx_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [7:0]           tok_byte_r;
  logic                 tok_end_r;
  logic                 run_last_r;
  logic                 slot_free;
  logic                 load;
  logic                 is_last;
  res_t                 cur;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign load = slot_free && !stat.empty;
  assign cur = head.res[idx_r];
  assign is_last = ({1'b0, idx_r} == RES_CNT_W'(head.cnt - RES_CNT_W'(1)));
  assign pop = load && is_last;

  always_comb begin
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt = is_last ? '0 : idx_r + RES_IDX_W'(1);
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_byte_r <= cur.tok_byte;
      tok_end_r <= cur.tok_end;
      run_last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.tok_byte = tok_byte_r;
  assign out_chan.tok_end = tok_end_r;
  assign out_chan.run_last = run_last_r;

endmodule
`default_nettype wire

// ----- hw/rtl/source_tokenizer_core.sv -----
// Channel    Port      Direction  Payload
// input      in_chan   sink       ch[7:0], final_req
// result     out_chan  source     tok_byte[7:0], tok_end, run_last
//
// The front end takes one byte per cycle while the four-entry queue has room.
// Each byte yields zero to four results, and the back end sends one per cycle while
// out_chan.ready is high, so the queue lets new bytes in while older results still wait.
// Results pass through a queue entry and then the output register before they appear.
// Reset is synchronous on rst_n and clears the lexer state, the queue and the output.
// A stalled output fills the queue, and then in_chan.ready drops.
`default_nettype none
module source_tokenizer_core
  import stk_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  stk_in_if.sink    in_chan,
  stk_out_if.source out_chan
);

  push_t   push;
  cmd_t    head;
  q_stat_t stat;
  logic    pop;

  stk_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (stat.full),
    .push    (push)
  );

  stk_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  stk_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .stat     (stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("Queue popped while empty.");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !stat.full)
    else $error("Queue pushed while full.");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (push.cmd.cnt != '0) && (push.cmd.cnt <= RES_CNT_W'(MAX_RES)))
    else $error("Pushed a command with an invalid result count.");

  a_pop_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_chan.valid && out_chan.run_last)
    else $error("Last result of a command is not marked.");

endmodule
`default_nettype wire

// ----- verif/source_tokenizer_core_test.sv -----
`default_nettype none
module source_tokenizer_core_test;
  import stk_pkg::*;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic       tok_end;
    logic       run_last;
  } token_beat_t;

  // Tracks the lexer state and queues the token results each source byte should produce.
  class lexer_tracker;
    mode_t             mode;
    logic [NEST_W-1:0] depth;
    bit                token_open;
    bit                slash_pending;
    bit                drop_next;
    token_beat_t       step_beats[$];
    token_beat_t       pending_beats[$];
    int                errors;
    int                bytes_seen;
    int                beats_seen;
    int                deepest;

    function new();
      clear_state();
      errors = 0;
      bytes_seen = 0;
      beats_seen = 0;
      deepest = 0;
    endfunction

    function void clear_state();
      mode = MODE_IDLE;
      depth = '0;
      token_open = 1'b0;
      slash_pending = 1'b0;
      drop_next = 1'b0;
    endfunction

    function void emit_byte(logic [7:0] b);
      if (step_beats.size() < MAX_RES) begin
        step_beats.insert(step_beats.size(),
                          '{tok_byte: b, tok_end: 1'b0, run_last: 1'b0});
      end
      token_open = 1'b1;
    endfunction

    function void close_token();
      if (token_open && step_beats.size() < MAX_RES) begin
        step_beats.insert(step_beats.size(),
                          '{tok_byte: 8'h00, tok_end: 1'b1, run_last: 1'b0});
      end
      token_open = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) ||
             (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function void plain(logic [7:0] c);
      if (is_blank(c)) begin
        close_token();
        mode = MODE_IDLE;
      end else if (c == CH_BSLASH) begin
        drop_next = 1'b1;
      end else if (c == CH_QUOTE) begin
        emit_byte(c);
        mode = MODE_QUOTE;
      end else if (c == CH_LPAREN) begin
        emit_byte(c);
        depth = NEST_W'(1);
        mode = MODE_PAREN;
      end else if ((c == CH_RPAREN) || (c == CH_LBRACK) || (c == CH_RBRACK)) begin
        close_token();
        emit_byte(c);
        close_token();
        mode = MODE_IDLE;
      end else if (c == CH_SLASH) begin
        slash_pending = 1'b1;
      end else begin
        emit_byte(c);
        mode = MODE_WORD;
      end
    endfunction

    function void advance(logic [7:0] c);
      if (drop_next) begin
        drop_next = 1'b0;
        return;
      end
      if (slash_pending) begin
        slash_pending = 1'b0;
        if (c == CH_SLASH) begin
          close_token();
          mode = MODE_COMMENT;
          return;
        end
        emit_byte(CH_SLASH);
        mode = MODE_WORD;
        plain(c);
        return;
      end
      case (mode)
        MODE_COMMENT: begin
          if (c == CH_NL) mode = MODE_IDLE;
        end
        MODE_QUOTE: begin
          if (c == CH_BSLASH) begin
            drop_next = 1'b1;
          end else if (c == CH_QUOTE) begin
            emit_byte(c);
            close_token();
            mode = MODE_IDLE;
          end else begin
            emit_byte(c);
          end
        end
        MODE_PAREN: begin
          emit_byte(c);
          if (c == CH_LPAREN) begin
            if (depth < NEST_W'(MAX_NEST)) depth = depth + 1'b1;
          end else if (c == CH_RPAREN) begin
            if (depth != 0) depth = depth - 1'b1;
            if (depth == 0) begin
              close_token();
              mode = MODE_IDLE;
            end
          end
        end
        default: plain(c);
      endcase
    endfunction

    function void note_byte(logic [7:0] c, logic fin);
      step_beats.delete();
      bytes_seen++;
      advance(c);
      if (int'(depth) > deepest) deepest = int'(depth);
      if (fin) begin
        if (slash_pending) begin
          slash_pending = 1'b0;
          emit_byte(CH_SLASH);
        end
        close_token();
        clear_state();
      end
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].run_last = 1'b1;
      foreach (step_beats[i]) pending_beats.insert(pending_beats.size(), step_beats[i]);
    endfunction

    function void check_beat(logic [7:0] b, logic e, logic l);
      token_beat_t want;
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $error("unexpected token result: tok_byte %0h tok_end %0b run_last %0b", b, e, l);
        errors++;
        return;
      end
      want = pending_beats.pop_front();
      if (b !== want.tok_byte) begin
        $error("tok_byte: expected %0h, got %0h", want.tok_byte, b);
        errors++;
      end
      if (e !== want.tok_end) begin
        $error("tok_end: expected %0b, got %0b", want.tok_end, e);
        errors++;
      end
      if (l !== want.run_last) begin
        $error("run_last: expected %0b, got %0b", want.run_last, l);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_beats.size();
    endfunction

    function void report_leftovers();
      if (pending_beats.size() != 0) begin
        $error("%0d token results never arrived", pending_beats.size());
        errors += pending_beats.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic [7:0] text_q[$];
  lexer_tracker tracker = new();

  stk_in_if  in_bus();
  stk_out_if out_bus();

  source_tokenizer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL source_tokenizer_core");
    $finish;
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        tracker.check_beat(out_bus.tok_byte, out_bus.tok_end, out_bus.run_last);
      end
      out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(logic [7:0] c, logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.ch <= c;
    in_bus.final_req <= fin;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    tracker.note_byte(c, fin);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_NL;
      2: return CH_TAB;
      3: return CH_CR;
      4: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic void append_char(logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  // Fills text_q with one lexical fragment and returns 1 when it must end the run.
  function automatic bit build_segment();
    int n;
    int d;
    text_q.delete();
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(1, 5);
        repeat (n) append_char(pick_letter());
      end
      1: append_char(pick_blank());
      2: begin
        append_char(CH_SLASH);
        append_char(CH_SLASH);
        n = $urandom_range(0, 4);
        repeat (n) append_char(8'($urandom_range(0, 255)));
        append_char(CH_NL);
      end
      3: begin
        append_char(CH_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: begin
              append_char(CH_BSLASH);
              append_char(8'($urandom_range(0, 255)));
            end
            1: append_char(8'($urandom_range(0, 255)));
            default: append_char(pick_letter());
          endcase
        end
        append_char(CH_QUOTE);
      end
      4: begin
        append_char(CH_LPAREN);
        d = 1;
        n = $urandom_range(0, 8);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: begin
              if (d < 4) begin
                append_char(CH_LPAREN);
                d++;
              end
            end
            1: begin
              if (d > 1) begin
                append_char(CH_RPAREN);
                d--;
              end
            end
            2: append_char(($urandom_range(0, 1) != 0) ? CH_BSLASH : CH_QUOTE);
            default: append_char(pick_letter());
          endcase
        end
        while (d > 0) begin
          append_char(CH_RPAREN);
          d--;
        end
      end
      5: begin
        case ($urandom_range(0, 2))
          0: append_char(CH_LBRACK);
          1: append_char(CH_RBRACK);
          default: append_char(CH_RPAREN);
        endcase
      end
      6: begin
        append_char(CH_BSLASH);
        append_char(8'($urandom_range(0, 255)));
      end
      7: begin
        append_char(CH_SLASH);
        append_char(8'($urandom_range(0, 255)));
      end
      8: append_char(8'($urandom_range(0, 255)));
      default: begin
        append_char(8'($urandom_range(0, 255)));
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic run_random(int count);
    int start;
    bit ends_run;
    logic fin;
    start = tracker.bytes_seen;
    while (tracker.bytes_seen - start < count) begin
      ends_run = build_segment();
      foreach (text_q[i]) begin
        fin = ($urandom_range(0, 24) == 0);
        if (ends_run && i == text_q.size() - 1) fin = 1'b1;
        send_byte(text_q[i], fin);
      end
    end
  endtask

  initial begin
    int k;
    in_bus.valid = 1'b0;
    in_bus.ch = 8'h00;
    in_bus.final_req = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_text("a(b\\) /x//z\n[q])\\]a\"e\\\"f\"");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_SLASH, 1'b1);
    drain_results();

    // Nesting opens a few levels, then closes and strays past zero.
    repeat (6) send_byte(CH_LPAREN, 1'b0);
    repeat (8) send_byte(CH_RPAREN, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 54;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 54;
        end
        default: begin
          send_idle_pct = 19;
          recv_stall_pct = 19;
        end
      endcase
      run_random(15);
    end

    in_bus.valid <= 1'b0;
    for (k = 0; k < 20000 && tracker.outstanding() != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    tracker.report_leftovers();

    $display("Run covered %0d source bytes and %0d token results, nesting up to depth %0d.",
             tracker.bytes_seen, tracker.beats_seen, tracker.deepest);
    if (tracker.errors == 0) begin
      $display("PASS source_tokenizer_core");
    end else begin
      $display("FAIL source_tokenizer_core");
    end
    $finish;
  end

endmodule
`default_nettype wire
